FILE: src/qbs_pkg.sv
// shared constants and types of the min/max quantizer with bit-plane split
`timescale 1ns / 1ps
package qbs_pkg;

  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int SAMPLE_BITS_DEF  = 16;

  // 8-bit codes, four elements to a group
  localparam int CODE_BITS  = 8;
  localparam int GROUP_SIZE = 4;
  localparam int SLOT_BITS  = $clog2(GROUP_SIZE);
  localparam int STEP_BITS  = $clog2(CODE_BITS);
  localparam int NIB_BITS   = 4;

  // divider result handed back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [CODE_BITS-1:0] quot;
  } qbs_div_res_t;

endpackage

FILE: src/qbs_store.sv
// sample store: one write port, one registered read port
`timescale 1ns / 1ps
module qbs_store import qbs_pkg::*; #(
  parameter int DEPTH = MAX_ELEMENTS_DEF,
  parameter int WIDTH = SAMPLE_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/qbs_div.sv
// restoring divider, one quotient bit per cycle, 8-bit quotient
`timescale 1ns / 1ps
module qbs_div import qbs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int NUM_BITS   = SAMPLE_BITS + CODE_BITS + 1,
  localparam int DEN_BITS   = SAMPLE_BITS + 1,
  localparam int SH_BITS    = DEN_BITS + CODE_BITS - 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output qbs_div_res_t        res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [NUM_BITS-1:0]  rem_r, rem_nxt;
  logic [SH_BITS-1:0]   dsh_r, dsh_nxt;
  logic [CODE_BITS-1:0] quot_r, quot_nxt;
  logic                 fits;

  // quotient stays below 256 so the divisor starts shifted by seven
  assign fits = (rem_r >= {1'b0, dsh_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = numer;
      dsh_nxt  = {denom, {(CODE_BITS-1){1'b0}}};
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - {1'b0, dsh_r};
      end
      quot_nxt = {quot_r[CODE_BITS-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + STEP_BITS'(1);
      if (step_r == STEP_BITS'(CODE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

FILE: src/minmax_quantizer_bitplane_split.sv
// top level: load, min/max tracking, quantize sequencer and bit-plane output
// load phase: one item per cycle, no result except for the item marked last
// quantize phase: per stored element a store read, numerator setup, divider steps and
//   write-back; slots past the count or flat range get code zero; then a group handoff
// in_stall is high for the whole quantize phase; results wait in one output register
// synchronous active-low reset clears control state; the sample store is not cleared
`timescale 1ns / 1ps
module minmax_quantizer_bitplane_split import qbs_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CODE_BITS-1:0]          out_base_byte,
  output logic [CODE_BITS-1:0]          out_refine_byte,
  output logic [CODE_BITS-1:0]          out_detail_pair_first,
  output logic [CODE_BITS-1:0]          out_detail_pair_second,
  output logic signed [SAMPLE_BITS-1:0] out_range_minimum,
  output logic signed [SAMPLE_BITS-1:0] out_range_maximum,
  output logic                          out_flat_range,
  output logic                          out_capacity_overflow,
  output logic                          out_last_group
);

  localparam int SB       = SAMPLE_BITS;
  localparam int CW       = $clog2(MAX_ELEMENTS + 1);
  localparam int IW       = $clog2(MAX_ELEMENTS + GROUP_SIZE);
  localparam int AW       = $clog2(MAX_ELEMENTS);
  localparam int NUM_BITS = SB + CODE_BITS + 1;

  // sequencer states
  localparam logic [2:0] S_LOAD = 3'd0;  // taking samples
  localparam logic [2:0] S_READ = 3'd1;  // issue store read or emit a zero code
  localparam logic [2:0] S_PREP = 3'd2;  // read data back, start divider
  localparam logic [2:0] S_DIV  = 3'd3;  // wait for quotient
  localparam logic [2:0] S_EMIT = 3'd4;  // group complete, load output register

  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(GROUP_SIZE - 1);

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic signed [SB-1:0] min_r, min_nxt;
  logic signed [SB-1:0] max_r, max_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CODE_BITS-1:0] codes_r [GROUP_SIZE];
  logic [CODE_BITS-1:0] codes_nxt [GROUP_SIZE];

  logic                 in_acc;
  logic                 has_room;
  logic                 idx_live;
  logic                 grp_last;
  logic                 flat_w;
  logic [SLOT_BITS-1:0] slot;
  logic                 advance;
  logic                 out_ld;
  logic                 emit;
  logic                 wr_en, rd_en, div_start;

  logic [SB-1:0]        rd_data;
  logic [SB-1:0]        rng_w;
  logic [SB-1:0]        diff_w;
  logic [NUM_BITS-1:0]  numer_w;
  qbs_div_res_t         div_res;

  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] base_r, refine_r, det0_r, det1_r;
  logic signed [SB-1:0] omin_r, omax_r;
  logic                 oflat_r, oovf_r, olast_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_LOAD);
  assign has_room = (count_r < CW'(MAX_ELEMENTS));
  assign idx_live = (idx_r < IW'(count_r));
  assign grp_last = ((idx_r + IW'(1)) >= IW'(count_r));
  assign flat_w   = (max_r == min_r);
  assign slot     = idx_r[SLOT_BITS-1:0];
  assign out_ld   = !out_valid_r || !out_stall;

  // max >= min once a sample is stored, so the difference fits unsigned
  assign rng_w  = SB'(max_r - min_r);
  assign diff_w = SB'($signed(rd_data) - min_r);
  // 2*255*(x-min) + d, the half-up rounding numerator over 2*d
  assign numer_w = (NUM_BITS'(diff_w) << (CODE_BITS + 1))
                 - (NUM_BITS'(diff_w) << 1)
                 + NUM_BITS'(rng_w);

  qbs_store #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (SB)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  qbs_div #(
    .SAMPLE_BITS (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer_w),
    .denom ({rng_w, 1'b0}),
    .res   (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ovf_nxt   = ovf_r;
    codes_nxt = codes_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    advance   = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            wr_en = 1'b1;
            if (in_sample < min_r) begin
              min_nxt = in_sample;
            end
            if (in_sample > max_r) begin
              max_nxt = in_sample;
            end
            count_nxt = count_r + CW'(1);
          end else begin
            // full store: drop the sample, still honor the last mark
            ovf_nxt = 1'b1;
          end
          if (in_last_sample) begin
            idx_nxt   = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (idx_live && !flat_w) begin
          rd_en     = 1'b1;
          state_nxt = S_PREP;
        end else begin
          // slot past the count or flat range: code zero
          codes_nxt[slot] = '0;
          advance         = 1'b1;
        end
      end
      S_PREP: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          codes_nxt[slot] = div_res.quot;
          advance         = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ld) begin
          emit    = 1'b1;
          idx_nxt = idx_r + IW'(1);
          if (grp_last) begin
            // tensor done: back to reset values for the next one
            count_nxt = '0;
            min_nxt   = {1'b0, {(SB-1){1'b1}}};
            max_nxt   = {1'b1, {(SB-1){1'b0}}};
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    if (advance) begin
      if (slot == SLOT_LAST) begin
        state_nxt = S_EMIT;
      end else begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_READ;
      end
    end
  end

  // output register empties when taken and refills from the sequencer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      min_r       <= {1'b0, {(SB-1){1'b1}}};
      max_r       <= {1'b1, {(SB-1){1'b0}}};
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    codes_r <= codes_nxt;
    if (emit) begin
      // bit planes: element 0 in the top bits
      base_r   <= {codes_r[0][7:6], codes_r[1][7:6], codes_r[2][7:6], codes_r[3][7:6]};
      refine_r <= {codes_r[0][5:4], codes_r[1][5:4], codes_r[2][5:4], codes_r[3][5:4]};
      det0_r   <= {codes_r[0][NIB_BITS-1:0], codes_r[1][NIB_BITS-1:0]};
      det1_r   <= {codes_r[2][NIB_BITS-1:0], codes_r[3][NIB_BITS-1:0]};
      omin_r   <= min_r;
      omax_r   <= max_r;
      oflat_r  <= flat_w;
      oovf_r   <= ovf_r;
      olast_r  <= grp_last;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_base_byte          = base_r;
  assign out_refine_byte        = refine_r;
  assign out_detail_pair_first  = det0_r;
  assign out_detail_pair_second = det1_r;
  assign out_range_minimum      = omin_r;
  assign out_range_maximum      = omax_r;
  assign out_flat_range         = oflat_r;
  assign out_capacity_overflow  = oovf_r;
  assign out_last_group         = olast_r;

endmodule

FILE: src/qbs_checker.sv
// port-level checks of the quantizer, bound to the top level
`timescale 1ns / 1ps
module qbs_checker import qbs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_last_sample,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [CODE_BITS-1:0]          out_base_byte,
  input logic [CODE_BITS-1:0]          out_refine_byte,
  input logic [CODE_BITS-1:0]          out_detail_pair_first,
  input logic [CODE_BITS-1:0]          out_detail_pair_second,
  input logic signed [SAMPLE_BITS-1:0] out_range_minimum,
  input logic signed [SAMPLE_BITS-1:0] out_range_maximum,
  input logic                          out_last_group
);

  // item marked last starts quantization, input closes at once
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_sample |=> in_stall)
    else $error("input still open after last item");

  // a flat range quantizes every element to zero
  a_flat_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_minimum == out_range_maximum |->
      out_base_byte == '0 && out_refine_byte == '0 &&
      out_detail_pair_first == '0 && out_detail_pair_second == '0)
    else $error("nonzero code on flat range");

  // a stored tensor never shows its minimum above its maximum
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_range_minimum <= out_range_maximum)
    else $error("range minimum above maximum");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_base_byte) &&
      $stable(out_detail_pair_first) && $stable(out_last_group))
    else $error("stalled item changed");

endmodule

bind minmax_quantizer_bitplane_split qbs_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_qbs_checker (.*);
